>>> sv/wpcd_pkg.sv
// ----------------------------------------------------------------------------
// wpcd_pkg: shared types and constants of the waveform peak column drawer
// Holds the register map, segment kinds, the command passed from the front
// to the back, and the finished segment record.
// ----------------------------------------------------------------------------
package wpcd_pkg;

  localparam int ROW_BITS     = 12;
  localparam int MAX_CHANNELS = 8;
  localparam int PHASE_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam int COL_BITS     = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int POS_BITS     = 48;
  localparam int RATIO_BITS   = 32;
  localparam int GAIN_BITS    = 20;
  localparam int CCOUNT_BITS  = 4;
  localparam int CSEL_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 32;

  // gain is unsigned, so one extra bit keeps the product signed
  localparam int PROD_BITS    = GAIN_BITS + 1 + SAMPLE_BITS;

  localparam int MAX_CMDS     = 3;
  localparam int CMD_DEPTH    = 4;
  localparam int OUT_DEPTH    = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ZOOM_MODE      = 3'd0,
    REG_SCALE_RATIO    = 3'd1,
    REG_FIRST_BOUNDARY = 3'd2,
    REG_START_COLUMN   = 3'd3,
    REG_GAIN           = 3'd4,
    REG_CENTER_ROW     = 3'd5,
    REG_CHANNEL_COUNT  = 3'd6,
    REG_CHANNEL_SELECT = 3'd7
  } wpcd_reg_t;

  typedef enum logic [1:0] {
    SEG_BAR     = 2'd0,
    SEG_CONNECT = 2'd1,
    SEG_HOLD    = 2'd2
  } wpcd_kind_t;

  typedef struct packed {
    logic                    zoom_mode;
    logic [RATIO_BITS-1:0]   scale_ratio;
    logic [RATIO_BITS-1:0]   first_boundary;
    logic [COL_BITS-1:0]     start_column;
    logic [GAIN_BITS-1:0]    gain;
    logic [ROW_BITS-1:0]     center_row;
    logic [CCOUNT_BITS-1:0]  channel_count;
    logic [CSEL_BITS-1:0]    channel_select;
  } wpcd_cfg_t;

  // One command: a segment to draw (emit) and/or a previous-row update.
  // Rows come from val_a / val_b through the gain, or from the previous row.
  typedef struct packed {
    logic                          emit;
    logic                          last;
    logic                          a_prev;
    logic                          set_prev;
    wpcd_kind_t                    kind;
    logic [COL_BITS-1:0]           col;
    logic [COL_BITS-1:0]           col_end;
    logic signed [SAMPLE_BITS-1:0] val_a;
    logic signed [SAMPLE_BITS-1:0] val_b;
  } wpcd_cmd_t;

  typedef struct packed {
    logic [COL_BITS-1:0] column;
    logic [COL_BITS-1:0] column_end;
    logic [ROW_BITS-1:0] row_from;
    logic [ROW_BITS-1:0] row_to;
    wpcd_kind_t          kind;
    logic                last;
  } wpcd_seg_t;

endpackage

>>> sv/wpcd_front.sv
// ----------------------------------------------------------------------------
// wpcd_front: sample classifier
// Picks the drawn channel, tracks column boundaries and the open run, and
// turns each accepted sample into up to three commands for the back end.
// ----------------------------------------------------------------------------
module wpcd_front
  import wpcd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  wpcd_cfg_t                     cfg,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_range,
  output logic                          q_push,
  output wpcd_cmd_t                     q_din,
  input  logic                          q_full
);

  localparam int CNT_BITS = $clog2(MAX_CMDS + 1);

  logic signed [SAMPLE_BITS-1:0] run_min, run_max;
  logic signed [SAMPLE_BITS-1:0] run_min_next, run_max_next;
  logic [COL_BITS-1:0]           cur_column, cur_column_next;
  logic [POS_BITS-1:0]           frame_position, frame_position_next;
  logic [POS_BITS-1:0]           boundary_position, boundary_position_next;
  logic [PHASE_BITS-1:0]         channel_phase, channel_phase_next;
  logic                          column_open, column_open_next;
  logic                          first_seen, first_seen_next;

  wpcd_cmd_t                     bundle [MAX_CMDS];
  wpcd_cmd_t                     bundle_next [MAX_CMDS];
  logic [CNT_BITS-1:0]           bcount, bcount_next;
  logic [CNT_BITS-1:0]           bidx;

  logic pending, accept;

  function automatic wpcd_cmd_t mk_cmd(
    input logic                          emit,
    input logic                          a_prev,
    input logic                          set_prev,
    input wpcd_kind_t                    kind,
    input logic [COL_BITS-1:0]           col,
    input logic [COL_BITS-1:0]           col_end,
    input logic signed [SAMPLE_BITS-1:0] val_a,
    input logic signed [SAMPLE_BITS-1:0] val_b
  );
    wpcd_cmd_t c;
    c.emit     = emit;
    c.last     = 1'b0;
    c.a_prev   = a_prev;
    c.set_prev = set_prev;
    c.kind     = kind;
    c.col      = col;
    c.col_end  = col_end;
    c.val_a    = val_a;
    c.val_b    = val_b;
    return c;
  endfunction

  assign pending = (bidx < bcount);
  assign q_push  = pending && !q_full;
  assign q_din   = bundle[bidx];
  // take a new sample once the last command of the current one goes out
  assign full    = pending && !(q_push && (bidx + 1'b1 == bcount));
  assign accept  = push && !full;

  always_comb begin
    logic [4:0]            cc;
    logic [4:0]            ph;
    logic [4:0]            ph_inc;
    logic                  selected;
    logic [RATIO_BITS-1:0] step;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   pos_end;
    logic [CNT_BITS-1:0]   n;
    logic [CNT_BITS-1:0]   li;
    logic                  any_emit;

    run_min_next           = run_min;
    run_max_next           = run_max;
    cur_column_next        = cur_column;
    frame_position_next    = frame_position;
    boundary_position_next = boundary_position;
    column_open_next       = column_open;
    first_seen_next        = first_seen;
    for (int i = 0; i < MAX_CMDS; i++) begin
      bundle_next[i] = '0;
    end
    n        = '0;
    li       = '0;
    any_emit = 1'b0;
    pos      = '0;
    pos_end  = '0;

    if (cfg.channel_count == '0) begin
      cc = 5'd1;
    end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
      cc = 5'(MAX_CHANNELS);
    end else begin
      cc = 5'(cfg.channel_count);
    end
    ph       = (5'(channel_phase) >= cc) ? 5'd0 : 5'(channel_phase);
    selected = (ph == 5'(cfg.channel_select));
    ph_inc   = ph + 5'd1;
    channel_phase_next = (ph_inc >= cc) ? '0 : PHASE_BITS'(ph_inc);

    step = (cfg.scale_ratio < 32'h0001_0000) ? 32'h0001_0000 : cfg.scale_ratio;

    if (selected) begin
      if (!cfg.zoom_mode) begin
        if (!first_seen) begin
          first_seen_next        = 1'b1;
          cur_column_next        = cfg.start_column;
          frame_position_next    = '0;
          boundary_position_next = (cfg.first_boundary == '0) ?
                                   POS_BITS'(step) : POS_BITS'(cfg.first_boundary);
          run_min_next           = sample;
          run_max_next           = sample;
          column_open_next       = 1'b1;
          bundle_next[n] = mk_cmd(1'b0, 1'b0, 1'b1, SEG_BAR,
                                  '0, '0, sample, sample);
          n = n + 1'b1;
        end else begin
          frame_position_next = frame_position + POS_BITS'(32'h0001_0000);
          if (!column_open) begin
            run_min_next     = sample;
            run_max_next     = sample;
            column_open_next = 1'b1;
            bundle_next[n] = mk_cmd(1'b0, 1'b0, 1'b1, SEG_BAR,
                                    '0, '0, sample, sample);
            n = n + 1'b1;
          end else if (frame_position_next >= boundary_position) begin
            bundle_next[n] = mk_cmd(1'b1, 1'b0, 1'b0, SEG_BAR,
                                    cur_column, cur_column, run_min, run_max);
            n = n + 1'b1;
            cur_column_next        = cur_column + 1'b1;
            boundary_position_next = boundary_position + POS_BITS'(step);
            if (sample < run_min || sample > run_max) begin
              bundle_next[n] = mk_cmd(1'b1, 1'b1, 1'b1, SEG_CONNECT,
                                      cur_column_next, cur_column_next,
                                      sample, sample);
            end else begin
              bundle_next[n] = mk_cmd(1'b0, 1'b0, 1'b1, SEG_BAR,
                                      '0, '0, sample, sample);
            end
            n = n + 1'b1;
            run_min_next = sample;
            run_max_next = sample;
          end else begin
            if (sample < run_min) run_min_next = sample;
            if (sample > run_max) run_max_next = sample;
            bundle_next[n] = mk_cmd(1'b0, 1'b0, 1'b1, SEG_BAR,
                                    '0, '0, sample, sample);
            n = n + 1'b1;
          end
        end
      end else begin
        if (!first_seen) begin
          pos = (POS_BITS'(cfg.start_column) << 16) + POS_BITS'(cfg.first_boundary);
        end else begin
          pos = frame_position + POS_BITS'(cfg.scale_ratio);
        end
        pos_end             = pos + POS_BITS'(cfg.scale_ratio);
        frame_position_next = pos;
        first_seen_next     = 1'b1;
        column_open_next    = 1'b0;
        cur_column_next     = pos[31:16];
        // the first step of a range starts on its own row
        bundle_next[n] = mk_cmd(1'b1, first_seen, 1'b1, SEG_CONNECT,
                                pos[31:16], pos[31:16], sample, sample);
        n = n + 1'b1;
        bundle_next[n] = mk_cmd(1'b1, 1'b0, 1'b0, SEG_HOLD,
                                pos[31:16] + 1'b1, pos_end[31:16],
                                sample, sample);
        n = n + 1'b1;
      end
    end

    if (end_of_range) begin
      if (column_open_next) begin
        bundle_next[n] = mk_cmd(1'b1, 1'b0, 1'b0, SEG_BAR,
                                cur_column_next, cur_column_next,
                                run_min_next, run_max_next);
        n = n + 1'b1;
      end
      column_open_next   = 1'b0;
      first_seen_next    = 1'b0;
      channel_phase_next = '0;
    end

    for (int i = 0; i < MAX_CMDS; i++) begin
      if (CNT_BITS'(i) < n && bundle_next[i].emit) begin
        li       = CNT_BITS'(i);
        any_emit = 1'b1;
      end
    end
    if (any_emit) begin
      bundle_next[li].last = 1'b1;
    end
    bcount_next = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min           <= '0;
      run_max           <= '0;
      cur_column        <= '0;
      frame_position    <= '0;
      boundary_position <= '0;
      channel_phase     <= '0;
      column_open       <= 1'b0;
      first_seen        <= 1'b0;
      bcount            <= '0;
      bidx              <= '0;
    end else if (accept) begin
      run_min           <= run_min_next;
      run_max           <= run_max_next;
      cur_column        <= cur_column_next;
      frame_position    <= frame_position_next;
      boundary_position <= boundary_position_next;
      channel_phase     <= channel_phase_next;
      column_open       <= column_open_next;
      first_seen        <= first_seen_next;
      bcount            <= bcount_next;
      bidx              <= '0;
    end else if (q_push) begin
      bidx <= bidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_CMDS; i++) begin
        bundle[i] <= bundle_next[i];
      end
    end
  end

endmodule

>>> sv/wpcd_cmd_queue.sv
// ----------------------------------------------------------------------------
// wpcd_cmd_queue: command queue between front and back
// Short first-in first-out store so that either side can stall alone.
// ----------------------------------------------------------------------------
module wpcd_cmd_queue
  import wpcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  wpcd_cmd_t din,
  output logic      full,
  input  logic      pop,
  output wpcd_cmd_t dout,
  output logic      empty
);

  localparam int PTR_BITS = $clog2(CMD_DEPTH);

  wpcd_cmd_t             mem [CMD_DEPTH];
  logic [PTR_BITS-1:0]   head, tail;
  logic [PTR_BITS:0]     count;

  assign full  = (count == (PTR_BITS+1)'(CMD_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push && !full) tail <= tail + 1'b1;
      if (pop && !empty) head <= head + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[tail] <= din;
  end

endmodule

>>> sv/wpcd_back.sv
// ----------------------------------------------------------------------------
// wpcd_back: segment builder
// Scales sample values to display rows, resolves the previous row and
// queues finished segments for the result side.
// ----------------------------------------------------------------------------
module wpcd_back
  import wpcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  wpcd_cfg_t cfg,
  input  wpcd_cmd_t q_dout,
  input  logic      q_empty,
  output logic      q_pop,
  output wpcd_seg_t seg,
  output logic      empty,
  input  logic      pop
);

  localparam int PTR_BITS = $clog2(OUT_DEPTH);
  localparam int R_BITS   = PROD_BITS + 1 - 16;
  localparam int ROW_W    = R_BITS + 1;

  logic                        a_valid;
  wpcd_cmd_t                   a_cmd;
  logic signed [PROD_BITS-1:0] a_prod_a, a_prod_b;
  logic [ROW_BITS-1:0]         prev_row;
  logic [ROW_BITS-1:0]         row_a, row_b;
  wpcd_seg_t                   seg_new;
  logic                        wr;

  wpcd_seg_t                   mem [OUT_DEPTH];
  logic [PTR_BITS-1:0]         head, tail;
  logic [PTR_BITS:0]           count;

  // row = center - floor((p + 2^15) / 2^16), held to the display
  function automatic logic [ROW_BITS-1:0] to_row(
    input logic signed [PROD_BITS-1:0] p,
    input logic [ROW_BITS-1:0]         center
  );
    logic signed [PROD_BITS:0] t;
    logic signed [R_BITS-1:0]  r;
    logic signed [ROW_W-1:0]   row;
    t   = (PROD_BITS+1)'(p) + (PROD_BITS+1)'(32768);
    r   = t[PROD_BITS:16];
    row = $signed(ROW_W'(center)) - ROW_W'(r);
    if (row < 0) begin
      return '0;
    end else if (row > $signed(ROW_W'({ROW_BITS{1'b1}}))) begin
      return '1;
    end else begin
      return row[ROW_BITS-1:0];
    end
  endfunction

  // leave room for the command in flight
  assign q_pop = !q_empty && ((int'(count) + int'(a_valid)) < OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_cmd    <= q_dout;
      a_prod_a <= $signed({1'b0, cfg.gain}) * q_dout.val_a;
      a_prod_b <= $signed({1'b0, cfg.gain}) * q_dout.val_b;
    end
  end

  always_comb begin
    row_a              = to_row(a_prod_a, cfg.center_row);
    row_b              = to_row(a_prod_b, cfg.center_row);
    seg_new.column     = a_cmd.col;
    seg_new.column_end = a_cmd.col_end;
    seg_new.row_from   = a_cmd.a_prev ? prev_row : row_a;
    seg_new.row_to     = row_b;
    seg_new.kind       = a_cmd.kind;
    seg_new.last       = a_cmd.last;
  end

  assign wr = a_valid && a_cmd.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_row <= '0;
    end else if (a_valid && a_cmd.set_prev) begin
      prev_row <= row_b;
    end
  end

  assign empty = (count == '0);
  assign seg   = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) tail <= tail + 1'b1;
      if (pop && !empty) head <= head + 1'b1;
      case ({wr, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[tail] <= seg_new;
  end

endmodule

>>> sv/waveform_peak_column_drawer_core.sv
// ----------------------------------------------------------------------------
// waveform_peak_column_drawer_core: min-max waveform column drawer
// Turns an interleaved 16-bit sample stream into display line segments.
// ----------------------------------------------------------------------------
// Each accepted sample becomes up to three internal commands (a run update,
// a min-max bar, a connector or a step and hold, a closing bar), and the
// front pushes one command per cycle while the queue is not full into a
// four-deep command queue; a new sample is taken in the cycle the previous
// sample's last command goes out. So a sample that only extends a column
// or is not on the drawn channel gives at most one command, a sample that
// closes a column or is drawn in expand mode gives two, and one that also
// ends the range up to three. The back end scales both rows of a command in
// one multiplier stage and places the segment in an eight-deep result queue,
// which it reaches through the command queue and that stage. Configuration
// is taken at once (cfg_ready is always high) and must be written while the
// block is idle. Nothing needs clearing after reset.
// ----------------------------------------------------------------------------
module waveform_peak_column_drawer_core
  import wpcd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_range,
  output logic                          empty,
  input  logic                          pop,
  output logic [COL_BITS-1:0]           column,
  output logic [COL_BITS-1:0]           column_end,
  output logic [ROW_BITS-1:0]           row_from,
  output logic [ROW_BITS-1:0]           row_to,
  output logic [1:0]                    segment_kind,
  output logic                          last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DAT_BITS-1:0]       cfg_data
);

  wpcd_cfg_t cfg;
  wpcd_cmd_t q_din, q_dout;
  wpcd_seg_t seg;
  logic      q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zoom_mode      <= 1'b0;
      cfg.scale_ratio    <= 32'h0001_0000;
      cfg.first_boundary <= 32'h0001_0000;
      cfg.start_column   <= '0;
      cfg.gain           <= 20'd4096;
      cfg.center_row     <= ROW_BITS'(2048);
      cfg.channel_count  <= 4'd1;
      cfg.channel_select <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (wpcd_reg_t'(cfg_index))
        REG_ZOOM_MODE:      cfg.zoom_mode      <= cfg_data[0];
        REG_SCALE_RATIO:    cfg.scale_ratio    <= cfg_data[RATIO_BITS-1:0];
        REG_FIRST_BOUNDARY: cfg.first_boundary <= cfg_data[RATIO_BITS-1:0];
        REG_START_COLUMN:   cfg.start_column   <= cfg_data[COL_BITS-1:0];
        REG_GAIN:           cfg.gain           <= cfg_data[GAIN_BITS-1:0];
        REG_CENTER_ROW:     cfg.center_row     <= cfg_data[ROW_BITS-1:0];
        REG_CHANNEL_COUNT:  cfg.channel_count  <= cfg_data[CCOUNT_BITS-1:0];
        REG_CHANNEL_SELECT: cfg.channel_select <= cfg_data[CSEL_BITS-1:0];
        default:            cfg                <= cfg;
      endcase
    end
  end

  wpcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .end_of_range (end_of_range),
    .q_push       (q_push),
    .q_din        (q_din),
    .q_full       (q_full)
  );

  wpcd_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  wpcd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_dout  (q_dout),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .seg     (seg),
    .empty   (empty),
    .pop     (pop)
  );

  assign column       = seg.column;
  assign column_end   = seg.column_end;
  assign row_from     = seg.row_from;
  assign row_to       = seg.row_to;
  assign segment_kind = seg.kind;
  assign last_of_run  = seg.last;

endmodule
